FILE: rtl/core/txcw_pkg.sv
// Shared constants for the text console writer: character codes, cell values, defaults.
`default_nettype none

package txcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Word function codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Control characters
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_TAB       = 8'd9;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_SPACE     = 8'h20;

    // Cell and colour values
    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]  FILL_RESET = 8'h07;

    // Newlines issued by one tab
    localparam logic [2:0] TAB_LINES = 3'd4;

endpackage : txcw_pkg

`default_nettype wire

FILE: rtl/core/text_console_writer_unit.sv
// Text console writer: text-mode screen store with cursor, scroll and cell access.
//
// Input words arrive on i_valid/o_ready, results leave on o_valid/i_ready; one
// result word per input word. fill_colour is to be written through i_cfg_wr_en
// and i_cfg_wr_data while the block is idle; the block itself does not enforce it.
// One word is worked on at a time by a small sequencer around a dual-port
// screen memory (one write and one registered read per cycle). Rows are kept
// in a circular order, so a scroll clears one physical row and bumps the top
// row pointer instead of copying the screen.
// A scroll blanks one row of COLUMNS cells; a tab runs four newlines, each
// with any scroll it brings. The result is loaded into the output register
// from the done state once the output is free.
// After reset all ROWS * 2^clog2(COLUMNS) memory words are swept to grey spaces
// (3200 at 80x25); o_ready stays low until the sweep ends. The cursor
// is cleared and fill colour returns to 7.
// A finished result waits in the output register; while the receiver stalls
// the block holds its next result and accepts no further word.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS = txcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = txcw_pkg::ROWS_DEF,
    localparam int LW     = $clog2(COLUMNS * ROWS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration
    input  wire logic          i_cfg_wr_en,
    input  wire logic [7:0]    i_cfg_wr_data,
    // input words
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_func,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [7:0]    i_char_color,
    input  wire logic [6:0]    i_cell_column,
    input  wire logic [4:0]    i_cell_row,
    input  wire logic [15:0]   i_cell_value,
    // result words
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [LW-1:0]      o_cursor_position,
    output logic [15:0]        o_read_data,
    output logic               o_scrolled
);

    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW        = RW + CW;
    localparam int DEPTH     = ROWS * (2 ** CW);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BSW    = 3'd4;
    localparam logic [2:0] ST_RD     = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_top, n_top;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [LW-1:0] r_cur_lin, n_cur_lin;
    logic [2:0]    r_lines, n_lines;
    logic          r_scr, n_scr;
    logic [15:0]   r_rd_res, n_rd_res;
    logic [7:0]    r_fill;

    // latched word
    logic [1:0]  r_func;
    logic [7:0]  r_ch;
    logic [7:0]  r_color;
    logic [6:0]  r_col;
    logic [4:0]  r_row;
    logic [15:0] r_value;

    // result register
    logic          r_o_valid;
    logic [LW-1:0] r_o_cur;
    logic [15:0]   r_o_rd;
    logic          r_o_scr;

    // screen memory
    logic [15:0]   r_mem [0:DEPTH-1];
    logic [15:0]   r_mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic          in_acc;
    logic          out_free;
    logic          cell_on_screen;
    logic [RW:0]   cur_sum;
    logic [RW:0]   cell_sum;
    logic [RW-1:0] cur_prow;
    logic [RW-1:0] cell_prow;
    logic          last_row;
    logic          last_col;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);

    assign o_valid           = r_o_valid;
    assign o_cursor_position = r_o_cur;
    assign o_read_data       = r_o_rd;
    assign o_scrolled        = r_o_scr;

    // Logical to physical row through the circular top pointer
    assign cur_sum   = (RW+1)'(r_cur_row) + (RW+1)'(r_top);
    assign cur_prow  = (cur_sum >= (RW+1)'(ROWS)) ? RW'(cur_sum - (RW+1)'(ROWS)) : RW'(cur_sum);
    assign cell_sum  = (RW+1)'(r_row[RW-1:0]) + (RW+1)'(r_top);
    assign cell_prow = (cell_sum >= (RW+1)'(ROWS)) ? RW'(cell_sum - (RW+1)'(ROWS))
                                                   : RW'(cell_sum);

    assign cell_on_screen = ({1'b0, r_col} < 8'(COLUMNS)) && ({1'b0, r_row} < 6'(ROWS));
    assign last_row = (r_cur_row == RW'(ROWS - 1));
    assign last_col = (r_cur_col == CW'(COLUMNS - 1));

    assign mem_raddr = {cell_prow, r_col[CW-1:0]};

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_top     = r_top;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_cur_lin = r_cur_lin;
        n_lines   = r_lines;
        n_scr     = r_scr;
        n_rd_res  = r_rd_res;
        mem_we    = 1'b0;
        mem_waddr = {cur_prow, r_cur_col};
        mem_wdata = {r_color, r_ch};

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = txcw_pkg::BLANK_CELL;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state  = ST_EXEC;
                    n_scr    = 1'b0;
                    n_rd_res = '0;
                    if (i_char_code == txcw_pkg::CODE_TAB) begin
                        n_lines = txcw_pkg::TAB_LINES;
                    end else if (i_char_code == txcw_pkg::CODE_NEWLINE) begin
                        n_lines = 3'd1;
                    end else begin
                        n_lines = 3'd0;
                    end
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                unique case (r_func)
                    txcw_pkg::FUNC_PUT: begin
                        priority if (r_ch == txcw_pkg::CODE_NEWLINE ||
                                     r_ch == txcw_pkg::CODE_TAB) begin
                            // one newline per pass
                            n_lines   = r_lines - 1'b1;
                            n_cur_col = '0;
                            if (last_row) begin
                                n_cur_lin = LW'(LAST_BASE);
                                n_scr     = 1'b1;
                                n_cnt     = '0;
                                n_state   = ST_SCROLL;
                            end else begin
                                n_cur_row = r_cur_row + 1'b1;
                                n_cur_lin = r_cur_lin + LW'(COLUMNS) - LW'(r_cur_col);
                                n_state   = (r_lines == 3'd1) ? ST_DONE : ST_EXEC;
                            end
                        end else if (r_ch == txcw_pkg::CODE_BACKSPACE) begin
                            // step back; blank written next cycle
                            if (r_cur_lin != '0) begin
                                n_cur_lin = r_cur_lin - 1'b1;
                                if (r_cur_col == '0) begin
                                    n_cur_col = CW'(COLUMNS - 1);
                                    n_cur_row = r_cur_row - 1'b1;
                                end else begin
                                    n_cur_col = r_cur_col - 1'b1;
                                end
                                n_state = ST_BSW;
                            end
                        end else begin
                            // printable: store and advance
                            mem_we = 1'b1;
                            if (last_col) begin
                                n_cur_col = '0;
                                if (last_row) begin
                                    n_cur_lin = LW'(LAST_BASE);
                                    n_scr     = 1'b1;
                                    n_cnt     = '0;
                                    n_state   = ST_SCROLL;
                                end else begin
                                    n_cur_row = r_cur_row + 1'b1;
                                    n_cur_lin = r_cur_lin + 1'b1;
                                end
                            end else begin
                                n_cur_col = r_cur_col + 1'b1;
                                n_cur_lin = r_cur_lin + 1'b1;
                            end
                        end
                    end
                    txcw_pkg::FUNC_READ: begin
                        if (cell_on_screen) begin
                            n_state = ST_RD;
                        end
                    end
                    txcw_pkg::FUNC_WRITE: begin
                        mem_we    = cell_on_screen;
                        mem_waddr = mem_raddr;
                        mem_wdata = r_value;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCROLL: begin
                // blank the old top row, which becomes the new last row
                mem_we    = 1'b1;
                mem_waddr = {r_top, r_cnt[CW-1:0]};
                mem_wdata = {r_fill, txcw_pkg::CODE_SPACE};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt[CW-1:0] == CW'(COLUMNS - 1)) begin
                    n_top   = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                    n_state = (r_lines == 3'd0) ? ST_DONE : ST_EXEC;
                end
            end
            ST_BSW: begin
                mem_we    = 1'b1;
                mem_wdata = {r_color, txcw_pkg::CODE_SPACE};
                n_state   = ST_DONE;
            end
            ST_RD: begin
                n_rd_res = r_mem_q;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_top     <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_cur_lin <= '0;
            r_lines   <= '0;
            r_scr     <= 1'b0;
            r_fill    <= txcw_pkg::FILL_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_top     <= n_top;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_cur_lin <= n_cur_lin;
            r_lines   <= n_lines;
            r_scr     <= n_scr;
            if (i_cfg_wr_en) begin
                r_fill <= i_cfg_wr_data;
            end
            if (r_state == ST_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_res <= n_rd_res;
        if (in_acc) begin
            r_func  <= i_func;
            r_ch    <= i_char_code;
            r_color <= i_char_color;
            r_col   <= i_cell_column;
            r_row   <= i_cell_row;
            r_value <= i_cell_value;
        end
        if (r_state == ST_DONE && out_free) begin
            r_o_cur <= r_cur_lin;
            r_o_rd  <= r_rd_res;
            r_o_scr <= r_scr;
        end
    end

    // Screen memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    // Cursor stays on screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_lin < LW'(COLUMNS * ROWS))
        else $error("cursor left the screen");

    // Linear cursor agrees with row and column when idle
    a_cursor_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |->
            (32'(r_cur_lin) == 32'(r_cur_row) * COLUMNS + 32'(r_cur_col)))
        else $error("linear cursor out of step with row and column");

    // Top row pointer wraps within the screen
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < RW'(ROWS - 1) || r_top == RW'(ROWS - 1))
        else $error("top row pointer beyond last row");

    // A scroll always leaves the cursor on the last row
    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |-> (o_cursor_position >= LW'(LAST_BASE)))
        else $error("scrolled word with cursor above last row");

endmodule : text_console_writer_unit

`default_nettype wire
